>>> rtl/core/sbmq_pkg.sv
// Shared types and constants for the shared-buffer multi-queue unit.
package sbmq_pkg;

  localparam int SLOTS_DEF       = 16;
  localparam int QUEUE_COUNT_DEF = 4;
  localparam int DATA_W          = 32;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_ENQ = 2'd0,
    ST_DEQ = 2'd1,
    ST_OVF = 2'd2,
    ST_UNF = 2'd3
  } status_t;

  localparam logic signed [DATA_W-1:0] DATA_UNDERFLOW = -32'sd1;
  localparam logic signed [DATA_W-1:0] DATA_NONE      = 32'sd0;

  typedef struct packed {
    op_t                      operation;
    logic [1:0]               queue_number;
    logic signed [DATA_W-1:0] data_in;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data_out;
    status_t                  status;
  } rsp_t;

endpackage

>>> rtl/core/shared_buffer_multi_queue_unit.sv
// Top level: several FIFO queues kept as linked lists in one shared slot store.
//
// Usage: drive cmd and raise start; a word is taken at each rising edge with
// start high and busy low. busy stays low, so a command can be issued every
// cycle. Each command gives exactly one response on rsp, flagged by done for
// one cycle, in the cycle right after the command was taken (throughput 1
// command per cycle). The receiver cannot stall; it must take
// rsp whenever done is high.
// An enqueue takes the first free slot and links it after the queue's tail.
// A dequeue returns the head slot's word and pushes the slot onto the free
// list. Overflow (no free slot or bad queue on enqueue) and underflow (empty
// or bad queue on dequeue, data -1) are reported in status.
// The rate is set by the link memory read: the next free slot or next head
// arrives in the next cycle and is forwarded to the following command.
// Reset (rst, synchronous) empties all queues and puts every slot on the
// free list in order; slots at or above a fill mark read as chained, so no
// clearing pass is needed and commands are taken right after reset.
module shared_buffer_multi_queue_unit import sbmq_pkg::*; #(
  parameter int SLOTS       = SLOTS_DEF,
  parameter int QUEUE_COUNT = QUEUE_COUNT_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  cmd_t cmd,
  output logic done,
  output rsp_t rsp
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PW = $clog2(SLOTS + 1);
  localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
  localparam logic [PW-1:0] NIL = PW'(SLOTS);

  // architectural state
  logic [PW-1:0] free_head, free_head_next;
  logic [PW-1:0] fresh, fresh_next;
  logic [PW-1:0] head      [QUEUE_COUNT];
  logic [PW-1:0] head_next [QUEUE_COUNT];
  logic [AW-1:0] tail      [QUEUE_COUNT];
  logic [AW-1:0] tail_next [QUEUE_COUNT];

  // response stage
  logic          pend_free;
  logic          pend_head;
  logic [QW-1:0] pq;
  logic          plast;
  logic [AW-1:0] rd_addr;
  logic          rd_fresh;
  status_t       st;

  // store interface
  logic                     link_we;
  logic [AW-1:0]            link_waddr;
  logic [PW-1:0]            link_wdata;
  logic                     word_we;
  logic [AW-1:0]            slot;
  logic [PW-1:0]            link_rdata;
  logic signed [DATA_W-1:0] word_rdata;

  logic          accept;
  logic          is_enq;
  logic          q_ok;
  logic [QW-1:0] qi;
  logic [PW-1:0] rd_link;
  logic [PW-1:0] nxt_link;
  logic [PW-1:0] pend_val;
  logic [PW-1:0] free_eff;
  logic [PW-1:0] head_sel;
  logic          enq_ok;
  logic          deq_ok;
  status_t       st_next;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign is_enq = (cmd.operation == OP_ENQ);
  assign q_ok   = (int'(cmd.queue_number) < QUEUE_COUNT);
  assign qi     = QW'(cmd.queue_number);

  // forward the link read of the previous word
  assign rd_link  = rd_fresh ? (PW'(rd_addr) + PW'(1)) : link_rdata;
  assign nxt_link = (rd_link >= NIL) ? NIL : rd_link;
  assign pend_val = plast ? NIL : nxt_link;
  assign free_eff = pend_free ? nxt_link : free_head;
  assign head_sel = (pend_head && (pq == qi)) ? pend_val : head[qi];

  assign enq_ok = accept && is_enq && q_ok && (free_eff != NIL);
  assign deq_ok = accept && !is_enq && q_ok && (head_sel != NIL);
  assign slot   = is_enq ? AW'(free_eff) : AW'(head_sel);

  always_comb begin
    free_head_next = free_eff;
    fresh_next     = fresh;
    link_we        = 1'b0;
    link_waddr     = slot;
    link_wdata     = free_eff;
    word_we        = 1'b0;
    for (int i = 0; i < QUEUE_COUNT; i++) begin
      head_next[i] = (pend_head && (int'(pq) == i)) ? pend_val : head[i];
      tail_next[i] = tail[i];
    end
    if (is_enq) begin
      st_next = enq_ok ? ST_ENQ : ST_OVF;
    end else begin
      st_next = deq_ok ? ST_DEQ : ST_UNF;
    end
    if (enq_ok) begin
      word_we       = 1'b1;
      tail_next[qi] = slot;
      if (PW'(slot) == fresh) begin
        fresh_next = fresh + PW'(1);
      end
      if (head_sel == NIL) begin
        head_next[qi] = PW'(slot);
      end else begin
        link_we    = 1'b1;
        link_waddr = tail[qi];
        link_wdata = PW'(slot);
      end
    end
    if (deq_ok) begin
      link_we        = 1'b1;
      link_waddr     = slot;
      link_wdata     = free_eff;
      free_head_next = PW'(slot);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_head <= '0;
      fresh     <= '0;
      done      <= 1'b0;
      pend_free <= 1'b0;
      pend_head <= 1'b0;
      for (int i = 0; i < QUEUE_COUNT; i++) begin
        head[i] <= NIL;
      end
    end else begin
      free_head <= free_head_next;
      fresh     <= fresh_next;
      done      <= accept;
      pend_free <= enq_ok;
      pend_head <= deq_ok;
      for (int i = 0; i < QUEUE_COUNT; i++) begin
        head[i] <= head_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_COUNT; i++) begin
      tail[i] <= tail_next[i];
    end
    pq       <= qi;
    plast    <= (slot == tail[qi]);
    rd_addr  <= slot;
    rd_fresh <= (PW'(slot) >= fresh);
    st       <= st_next;
  end

  sbmq_store #(
    .SLOTS(SLOTS)
  ) u_store (
    .clk        (clk),
    .link_we    (link_we),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata),
    .word_we    (word_we),
    .word_waddr (slot),
    .word_wdata (cmd.data_in),
    .raddr      (slot),
    .link_rdata (link_rdata),
    .word_rdata (word_rdata)
  );

  always_comb begin
    rsp.status = st;
    case (st)
      ST_DEQ:  rsp.data_out = word_rdata;
      ST_UNF:  rsp.data_out = DATA_UNDERFLOW;
      default: rsp.data_out = DATA_NONE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_pend_excl: assert property (@(posedge clk) disable iff (rst)
    !(pend_free && pend_head))
    else $error("free and head updates pending together");

  a_fresh_range: assert property (@(posedge clk) disable iff (rst)
    fresh <= PW'(SLOTS))
    else $error("fill mark beyond store");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("command without response");

  a_deq_status: assert property (@(posedge clk) disable iff (rst)
    deq_ok |=> (done && st == ST_DEQ && pend_head))
    else $error("dequeue response lost");
`endif

endmodule

>>> rtl/core/sbmq_store.sv
// Link and word memories with one write and one registered read each.
module sbmq_store import sbmq_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF,
  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int PW = $clog2(SLOTS + 1)
) (
  input  logic                     clk,
  input  logic                     link_we,
  input  logic [AW-1:0]            link_waddr,
  input  logic [PW-1:0]            link_wdata,
  input  logic                     word_we,
  input  logic [AW-1:0]            word_waddr,
  input  logic signed [DATA_W-1:0] word_wdata,
  input  logic [AW-1:0]            raddr,
  output logic [PW-1:0]            link_rdata,
  output logic signed [DATA_W-1:0] word_rdata
);

  logic [PW-1:0]            link_mem [SLOTS];
  logic signed [DATA_W-1:0] word_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_rdata <= link_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (word_we) begin
      word_mem[word_waddr] <= word_wdata;
    end
    word_rdata <= word_mem[raddr];
  end

endmodule

>>> tb/sv/shared_buffer_multi_queue_unit_test.sv
// Self-checking testbench for the shared-buffer multi-queue unit.
module shared_buffer_multi_queue_unit_test import sbmq_pkg::*; ();

  localparam int SLOTS      = SLOTS_DEF;
  localparam int QUEUES     = QUEUE_COUNT_DEF;
  localparam int NIL        = SLOTS;
  localparam int STALL_MAX  = 1000;
  localparam int PHASE_LEN  = 410;
  localparam int PRINT_MAX  = 50;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic done;
  cmd_t cmd;
  rsp_t rsp;

  shared_buffer_multi_queue_unit #(
    .SLOTS(SLOTS),
    .QUEUE_COUNT(QUEUES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .done(done),
    .rsp(rsp)
  );

  logic [DATA_W-1:0] slot_word [SLOTS];
  int slot_link [SLOTS];
  int queue_head [QUEUES];
  int queue_tail [QUEUES];
  int free_head;
  int used_slots;
  rsp_t pending_replies [$];
  int mismatch_count = 0;
  int idle_pct = 0;
  int stall_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void reset_queue_state();
    for (int i = 0; i < SLOTS; i++) begin
      slot_word[i] = '0;
      slot_link[i] = i + 1;
    end
    for (int i = 0; i < QUEUES; i++) begin
      queue_head[i] = NIL;
      queue_tail[i] = 0;
    end
    free_head  = 0;
    used_slots = 0;
  endfunction

  // Applies one command to the shadow queues and returns the reply it should get.
  function automatic rsp_t apply_queue_command(input cmd_t c);
    rsp_t r;
    int q;
    int slot;
    q = c.queue_number;
    if (c.operation == OP_ENQ) begin
      r.data_out = DATA_NONE;
      if (q >= QUEUES || free_head == NIL) begin
        r.status = ST_OVF;
      end else begin
        slot      = free_head;
        free_head = slot_link[slot];
        if (queue_head[q] == NIL) begin
          queue_head[q] = slot;
        end else begin
          slot_link[queue_tail[q]] = slot;
        end
        slot_link[slot] = NIL;
        queue_tail[q]   = slot;
        slot_word[slot] = c.data_in;
        used_slots++;
        r.status = ST_ENQ;
      end
    end else if (q >= QUEUES || queue_head[q] == NIL) begin
      r.data_out = DATA_UNDERFLOW;
      r.status   = ST_UNF;
    end else begin
      slot            = queue_head[q];
      queue_head[q]   = slot_link[slot];
      slot_link[slot] = free_head;
      free_head       = slot;
      used_slots--;
      r.data_out = slot_word[slot];
      r.status   = ST_DEQ;
    end
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] random_word();
    case ($urandom_range(7))
      0: return {1'b1, {(DATA_W-1){1'b0}}};
      1: return {1'b0, {(DATA_W-1){1'b1}}};
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic cmd_t make_cmd(input op_t op, input int q, input logic [DATA_W-1:0] d);
    cmd_t c;
    c.operation    = op;
    c.queue_number = q[1:0];
    c.data_in      = d;
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_MAX) $display("ERROR @%0t: %s", $time, msg);
  endtask

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input cmd_t c);
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy !== 1'b0);
    pending_replies.push_back(apply_queue_command(c));
    @(negedge clk);
  endtask

  task automatic maybe_idle();
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      cmd   <= make_cmd(op_t'($urandom_range(1)), $urandom_range(QUEUES - 1), $urandom);
      @(negedge clk);
    end
  endtask

  task automatic wait_for_replies();
    start <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
  endtask

  task automatic test_underflow_on_empty();
    send_word(make_cmd(OP_DEQ, 0, $urandom));
    send_word(make_cmd(OP_DEQ, QUEUES - 1, $urandom));
  endtask

  task automatic test_extreme_words();
    send_word(make_cmd(OP_ENQ, 0, {1'b1, {(DATA_W-1){1'b0}}}));
    send_word(make_cmd(OP_ENQ, 1, {1'b0, {(DATA_W-1){1'b1}}}));
    send_word(make_cmd(OP_ENQ, 2, '1));
    send_word(make_cmd(OP_ENQ, 3, '0));
    send_word(make_cmd(OP_DEQ, 1, '0));
    send_word(make_cmd(OP_DEQ, 3, '1));
  endtask

  task automatic test_overflow_when_full();
    int q;
    q = 0;
    while (used_slots < SLOTS) begin
      send_word(make_cmd(OP_ENQ, q, random_word()));
      q = (q + 1) % QUEUES;
    end
    send_word(make_cmd(OP_ENQ, 2, random_word()));
    wait_for_replies();
  endtask

  // Bursts lean toward filling or draining so the store swings between full and empty.
  task automatic test_mixed_traffic(input int items, input int pct, input bit drain_midway);
    int sent;
    int burst;
    int enq_pct;
    int focus;
    cmd_t c;
    sent = 0;
    while (sent < items) begin
      burst    = $urandom_range(8, 40);
      enq_pct  = $urandom_range(1) ? 80 : 20;
      focus    = ($urandom_range(3) == 0) ? $urandom_range(QUEUES - 1) : -1;
      idle_pct = ($urandom_range(3) == 0) ? 0 : pct;
      repeat (burst) begin
        c.operation    = ($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ;
        c.queue_number = (focus >= 0) ? focus[1:0] : 2'($urandom_range(QUEUES - 1));
        c.data_in      = random_word();
        maybe_idle();
        send_word(c);
        sent++;
        if (drain_midway && sent == items / 2) wait_for_replies();
      end
    end
    idle_pct = 0;
  endtask

  always @(posedge clk) begin : check_replies
    rsp_t want;
    if (!rst && done !== 1'b0) begin
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("reply with none pending: data %0d status %0d",
                                  rsp.data_out, rsp.status));
      end else begin
        want = pending_replies.pop_front();
        if (rsp.status !== want.status)
          report_mismatch($sformatf("status %0d, want %s", rsp.status, want.status.name()));
        if (rsp.data_out !== want.data_out)
          report_mismatch($sformatf("data_out %0d, want %0d", rsp.data_out, want.data_out));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && busy === 1'b0) || done === 1'b1) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_MAX) begin
        $display("shared_buffer_multi_queue_unit: mismatch");
        $finish;
      end
    end
  end

  initial begin
    rst   = 1'b1;
    start = 1'b0;
    cmd   = '0;
    reset_queue_state();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_underflow_on_empty();
    test_extreme_words();
    test_overflow_when_full();
    test_mixed_traffic(PHASE_LEN, 34, 1'b0);
    test_mixed_traffic(PHASE_LEN, 53, 1'b1);
    test_mixed_traffic(PHASE_LEN, 0, 1'b0);

    wait_for_replies();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && pending_replies.size() == 0) begin
      $display("shared_buffer_multi_queue_unit: match");
    end else begin
      $display("shared_buffer_multi_queue_unit: mismatch");
    end
    $finish;
  end

endmodule
